>>> hw/rtl/ttc_pkg.sv
// Shared types and constants for the time-to-collision check.
package ttc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int IN_DATA_W = 9 * COORD_W;
  localparam int OUT_DATA_W = 40;
  localparam int SQ_W = 64;
  localparam int ROOT_STEPS = SQ_W / 2;

  // Control that travels beside the datapath of each stage.
  typedef struct packed {
    logic valid;
    logic in_path;
  } side_t;

endpackage

>>> hw/rtl/ttc_front.sv
// Angle span test and squared lengths, three register stages.
module ttc_front import ttc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_DATA_W-1:0] in_data,
  output side_t                side,
  output logic [SQ_W-1:0]      c2,
  output logic [SQ_W-1:0]      v2
);

  typedef struct packed {
    logic signed [1:0]  rank;
    logic signed [32:0] n;
    logic signed [32:0] d;
  } angle_t;

  function automatic angle_t make_angle(input logic signed [31:0] num,
                                        input logic signed [31:0] den);
    angle_t a;
    a.rank = 2'sd0;
    a.n = 33'sd0;
    a.d = 33'sd1;
    if (den == 32'sd0) begin
      if (num > 32'sd0) a.rank = 2'sd1;
      else if (num < 32'sd0) a.rank = -2'sd1;
    end else if (den < 32'sd0) begin
      a.n = -{num[31], num};
      a.d = -{den[31], den};
    end else begin
      a.n = {num[31], num};
      a.d = {den[31], den};
    end
    return a;
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  logic signed [31:0] f [0:8];
  angle_t corner_a [0:3];
  angle_t head_a;
  logic [31:0] mag_a [0:4];
  logic vzero_a, valid_a;

  logic signed [65:0] pl_b [0:3];
  logic signed [65:0] pr_b [0:3];
  logic signed [1:0]  rc_b [0:3];
  logic signed [1:0]  rh_b;
  logic [63:0] sq_b [0:4];
  logic vzero_b, valid_b;

  logic valid_c, in_path_c;

  logic below, above;

  assign side = {valid_c, in_path_c};

  always_comb begin
    for (int i = 0; i < 9; i++) f[i] = in_data[i*COORD_W +: COORD_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_a <= make_angle(f[1], f[0]);
      corner_a[0] <= make_angle(f[6], f[5]);
      corner_a[1] <= make_angle(f[6], f[7]);
      corner_a[2] <= make_angle(f[8], f[5]);
      corner_a[3] <= make_angle(f[8], f[7]);
      mag_a[0] <= mag(f[0]);
      mag_a[1] <= mag(f[1]);
      mag_a[2] <= mag(f[2]);
      mag_a[3] <= mag(f[3]);
      mag_a[4] <= mag(f[4]);
      vzero_a <= (f[0] == 32'sd0) && (f[1] == 32'sd0);

      for (int i = 0; i < 4; i++) begin
        pl_b[i] <= corner_a[i].n * head_a.d;
        pr_b[i] <= head_a.n * corner_a[i].d;
        rc_b[i] <= corner_a[i].rank;
      end
      rh_b <= head_a.rank;
      for (int i = 0; i < 5; i++) sq_b[i] <= mag_a[i] * mag_a[i];
      vzero_b <= vzero_a;

      in_path_c <= below && above && !vzero_b;
      c2 <= sq_b[2] + sq_b[3] + sq_b[4];
      v2 <= sq_b[0] + sq_b[1];
    end
  end

  // A corner at or below the heading sets below, at or above sets above.
  always_comb begin
    below = 1'b0;
    above = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (rc_b[i] != rh_b) begin
        if (rc_b[i] < rh_b) below = 1'b1;
        else above = 1'b1;
      end else if (rc_b[i] != 2'sd0) begin
        below = 1'b1;
        above = 1'b1;
      end else begin
        if (pl_b[i] <= pr_b[i]) below = 1'b1;
        if (pl_b[i] >= pr_b[i]) above = 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ttc_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
module ttc_div import ttc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  side_t           side_in,
  input  logic [SQ_W-1:0] num,
  input  logic [SQ_W-1:0] den,
  output side_t           side_out,
  output logic [SQ_W-1:0] quo
);

  localparam int QW = SQ_W + 2 * FRAC_BITS;

  side_t           s_st [0:QW];
  logic [SQ_W-1:0] n_st [0:QW];
  logic [SQ_W-1:0] d_st [0:QW];
  logic [SQ_W-1:0] r_st [0:QW];
  logic [QW-1:0]   q_st [0:QW];

  assign s_st[0] = side_in;
  assign n_st[0] = num;
  assign d_st[0] = den;
  assign r_st[0] = '0;
  assign q_st[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [SQ_W:0] trial;
    logic          fits;
    assign trial = {r_st[i], n_st[i][SQ_W-1]};
    assign fits = trial >= {1'b0, d_st[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        s_st[i+1].valid <= 1'b0;
      end else if (en) begin
        s_st[i+1] <= s_st[i];
        n_st[i+1] <= {n_st[i][SQ_W-2:0], 1'b0};
        d_st[i+1] <= d_st[i];
        r_st[i+1] <= fits ? SQ_W'(trial - {1'b0, d_st[i]}) : trial[SQ_W-1:0];
        q_st[i+1] <= {q_st[i][QW-2:0], fits};
      end
    end
  end

  assign side_out = s_st[QW];
  assign quo = (q_st[QW][QW-1:SQ_W] != '0) ? '1 : q_st[QW][SQ_W-1:0];

endmodule

>>> hw/rtl/ttc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ttc_sqrt import ttc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  side_t           side_in,
  input  logic [SQ_W-1:0] rad,
  output side_t           side_out,
  output logic [31:0]     root
);

  side_t           s_st [0:ROOT_STEPS];
  logic [SQ_W-1:0] x_st [0:ROOT_STEPS];
  logic [SQ_W-1:0] r_st [0:ROOT_STEPS];

  assign s_st[0] = side_in;
  assign x_st[0] = rad;
  assign r_st[0] = '0;

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W:0] trial;
    logic          fits;
    assign trial = {1'b0, r_st[k]} + {1'b0, BIT};
    assign fits = {1'b0, x_st[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        s_st[k+1].valid <= 1'b0;
      end else if (en) begin
        s_st[k+1] <= s_st[k];
        x_st[k+1] <= fits ? SQ_W'({1'b0, x_st[k]} - trial) : x_st[k];
        r_st[k+1] <= fits ? (r_st[k] >> 1) + BIT : r_st[k] >> 1;
      end
    end
  end

  assign side_out = s_st[ROOT_STEPS];
  assign root = r_st[ROOT_STEPS][31:0];

endmodule

>>> hw/rtl/time_to_collision_check.sv
// Top level of the time-to-collision check.
//
//  channel   direction  payload (low bit first)
//  s_*       in         vel_x, vel_y, center_x, center_y, center_z,
//                       box_min_x, box_min_y, box_max_x, box_max_y (32 b each)
//  m_*       out        ttc (32 b), in_path (1 b), zero fill to 40 b
//
// One item is accepted per cycle while the output is not held. Items pass through the
// front stages, the one-bit-per-stage divider and square root, and the output register.
// Reset clears all valid bits; no state is carried between items.
// When the output item is held, every stage holds and s_tready falls.
module time_to_collision_check import ttc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // vel_x, vel_y, center_x..z, box_min_x/y, box_max_x/y
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // ttc [31:0], in_path [32], zeros above
);

  logic            en;
  side_t           side_f, side_d, side_s;
  logic [SQ_W-1:0] c2, v2, quo;
  logic [31:0]     root;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  ttc_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid), .in_data(s_tdata),
    .side(side_f), .c2(c2), .v2(v2)
  );

  ttc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .side_in(side_f), .num(c2), .den(v2),
    .side_out(side_d), .quo(quo)
  );

  ttc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .side_in(side_d), .rad(quo),
    .side_out(side_s), .root(root)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= side_s.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {(OUT_DATA_W - 33)'(0), side_s.in_path,
                  side_s.in_path ? root : 32'd0};
    end
  end

endmodule

>>> hw/rtl/ttc_check.sv
// Port-level checker for the time-to-collision check, bound to the top level.
module ttc_check import ttc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output item dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("output item changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("input stalled with empty output");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
    else $error("nonzero ttc outside path");

endmodule

bind time_to_collision_check ttc_check u_ttc_check (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> verif/time_to_collision_check_checker.sv
// Checker for the time-to-collision block: predicts each result and compares it.
`timescale 1ns / 1ps
module time_to_collision_check_checker import ttc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [31:0] ttc;
    logic        in_path;
  } ttc_result_t;

  // Angle as a rank (-1 for -pi/2, +1 for +pi/2, 0 for a finite ratio) and a ratio.
  typedef struct {
    int                 rank;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } angle_t;

  ttc_result_t expected_q[$];

  function automatic angle_t to_angle(logic signed [63:0] n, logic signed [63:0] d);
    angle_t a;
    a.num = 0;
    a.den = 1;
    a.rank = 0;
    if (d == 0) a.rank = (n > 0) ? 1 : ((n < 0) ? -1 : 0);
    else if (d < 0) begin
      a.num = -n;
      a.den = -d;
    end else begin
      a.num = n;
      a.den = d;
    end
    return a;
  endfunction

  function automatic int angle_order(angle_t a, angle_t b);
    logic signed [127:0] l, r;
    if (a.rank != b.rank) return (a.rank < b.rank) ? -1 : 1;
    if (a.rank != 0) return 0;
    l = a.num * b.den;
    r = b.num * a.den;
    return (l < r) ? -1 : ((l > r) ? 1 : 0);
  endfunction

  function automatic logic [63:0] square_mag(logic signed [31:0] x);
    logic [63:0] m;
    m = (x < 0) ? 64'(-64'(x)) : 64'(x);
    return m * m;
  endfunction

  // floor(sqrt(floor(c2 * 2^(2F) / v2))), with the quotient saturated to 64 bits.
  function automatic logic [31:0] ttc_of(logic [63:0] c2, logic [63:0] v2);
    logic [159:0] q;
    logic [63:0] qs, root;
    logic [127:0] trial;
    q = ({96'd0, c2} << (2 * FRAC_BITS)) / v2;
    qs = (q > 160'hFFFF_FFFF_FFFF_FFFF) ? '1 : q[63:0];
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = (root | (64'd1 << b));
      if (trial * trial <= qs) root = root | (64'd1 << b);
    end
    return root[31:0];
  endfunction

  function automatic ttc_result_t predict_ttc(logic [IN_DATA_W-1:0] d);
    ttc_result_t r;
    logic signed [31:0] vx, vy, cx, cy, cz, nx, ny, mx, my;
    angle_t head;
    angle_t corner[4];
    logic below, above;
    int k;
    {my, mx, ny, nx, cz, cy, cx, vy, vx} = d;
    r.ttc = 0;
    r.in_path = 0;
    below = 0;
    above = 0;
    if (vx == 0 && vy == 0) return r;
    head = to_angle(vy, vx);
    corner[0] = to_angle(ny, nx);
    corner[1] = to_angle(ny, mx);
    corner[2] = to_angle(my, nx);
    corner[3] = to_angle(my, mx);
    for (int i = 0; i < 4; i++) begin
      k = angle_order(corner[i], head);
      if (k <= 0) below = 1;
      if (k >= 0) above = 1;
    end
    if (below && above) begin
      r.in_path = 1;
      r.ttc = ttc_of(square_mag(cx) + square_mag(cy) + square_mag(cz),
                     square_mag(vx) + square_mag(vy));
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ttc_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_q = {expected_q, predict_ttc(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", m_tdata[31:0], 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[31:0] !== want.ttc) report("ttc", m_tdata[31:0], want.ttc);
          if (m_tdata[32] !== want.in_path) report("in_path", m_tdata[32], want.in_path);
          if (m_tdata[OUT_DATA_W-1:33] !== '0) report("fill", m_tdata[OUT_DATA_W-1:33], 0);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

>>> verif/time_to_collision_check_tb.sv
// Testbench top for the time-to-collision block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module time_to_collision_check_tb;
  import ttc_pkg::*;

  localparam int LATENCY = 3 + 64 + 2 * FRAC_BITS_DEF + 32 + 1;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MAXN = 32'h8000_0000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [OUT_DATA_W-1:0] m_tdata;
  int errors, pending;
  int idle_cycles;
  logic timed_out;

  time_to_collision_check DUT (.*);
  time_to_collision_check_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls in its own pattern; some stretches never stall.
  initial begin
    int mode;
    m_tready = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 1) != 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 0;
    wait (idle_cycles >= WATCHDOG_LIMIT);
    timed_out = 1;
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40)) - 20) << 16;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return '0;
      4: return $urandom_range(0, 1) ? MAXP : MAXN;
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  // Holds s_tvalid through the handshake; s_tvalid is lowered by the caller's gaps.
  task automatic send_item(logic [31:0] vx, vy, cx, cy, cz, nx, ny, mx, my);
    s_tdata <= {my, mx, ny, nx, cz, cy, cx, vy, vx};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic gap();
    s_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  initial begin
    logic [31:0] vx, vy, lo, hi;
    int burst;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: zero speed, vertical heading, 0/0 corners, extremes, saturation.
    send_item(0, 0, ONE, ONE, 0, -ONE, -ONE, ONE, ONE);
    send_item(ONE, 0, 10 * ONE, 0, 0, ONE, -ONE, 2 * ONE, ONE);
    send_item(ONE, 0, 10 * ONE, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
    send_item(0, ONE, 0, 5 * ONE, 0, -ONE, ONE, ONE, 2 * ONE);
    send_item(0, MAXN, 0, 0, 0, -ONE, -ONE, ONE, ONE);
    send_item(ONE, ONE, 0, 0, 0, 0, 0, 0, 0);
    send_item(ONE, ONE, 0, 0, 0, 0, 0, ONE, ONE);
    send_item(1, 0, MAXP, MAXN, MAXN, ONE, -ONE, ONE, ONE);
    send_item(MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXP, MAXP);
    send_item(MAXP, MAXP, MAXP, MAXP, MAXP, MAXN, MAXN, MAXP, MAXP);
    send_item(-ONE, 0, -3 * ONE, 0, ONE, -2 * ONE, -ONE, -ONE, ONE);
    send_item(-ONE, ONE, 0, 0, 0, -ONE, ONE, -ONE, ONE);
    send_item(ONE, -ONE, 4 * ONE, 0, 0, 0, -ONE, ONE, 0);
    send_item('1, '1, '1, '1, '1, '1, '1, '1, '1);
    send_item(MAXP, 1, 1, 0, 0, MAXP, 0, MAXP, 1);
    s_tvalid <= 0;

    // Hold off until every expected result has come.
    wait (pending == 0);
    @(negedge clk);

    for (int n = 0; n < 600; ) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        vx = rand_coord();
        vy = rand_coord();
        if ($urandom_range(0, 3) != 0) begin
          // Box built to straddle the heading ray so the in-path branch is reached.
          lo = 32'($signed($urandom_range(0, 8)) + 1) << 16;
          hi = lo + (32'($urandom_range(1, 6)) << 16);
          if ($signed(vx) < 0) begin
            lo = -lo;
            hi = -hi;
          end
          send_item(vx, vy, rand_coord(), rand_coord(), rand_coord(),
                    lo, 32'($signed(vy) >>> 8) - (ONE << 3), hi,
                    32'($signed(vy) >>> 8) + (ONE << 3));
        end else begin
          send_item(vx, vy, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        n++;
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    s_tvalid <= 0;

    wait (pending == 0 || timed_out);
    repeat (LATENCY + 10) @(posedge clk);
    if (timed_out) begin
      $display("*** FAILED ***");
    end else if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("watchdog expired with %0d items outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
